### src/ip_rtbf_pkg.sv
// ============================================================================
// ip_rtbf_pkg
// Shared types and action codes for the IPv4 range block/trust filter.
// ============================================================================
package ip_rtbf_pkg;

    // Action codes carried in the input transaction
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic        entry_is_block;
        logic [31:0] ip_address;
    } s_payload_t;

    typedef struct packed {
        logic is_blocked;
        logic table_full;
    } m_payload_t;

    // Transaction token as it travels down the cell chain
    typedef struct packed {
        logic        valid;
        logic [1:0]  action;
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic        entry_is_block;
        logic [31:0] ip_address;
        logic        table_full;
        logic        trust_any;
        logic        empty;
        logic        hit_block;
        logic        hit_trust;
    } tok_t;

endpackage

### src/ip_rtbf_cell.sv
// ============================================================================
// ip_rtbf_cell
// One table entry: stores a range on append, checks it on lookup, and hands
// the token to the next cell.
// ============================================================================
module ip_rtbf_cell
    import ip_rtbf_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int CELL_INDEX  = 0,
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  tok_t             tok_in,
    input  logic [CNT_W-1:0] used_in,
    output tok_t             tok_out,
    output logic [CNT_W-1:0] used_out
);

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(CELL_INDEX);

    // entry storage, no reset: only read below the fill count
    logic [31:0] start_reg;
    logic [31:0] end_reg;
    logic        block_reg;

    tok_t             tok_reg;
    tok_t             tok_next;
    logic [CNT_W-1:0] used_reg;
    logic             wr_en;
    logic             match;

    assign wr_en = advance && tok_in.valid && (tok_in.action == ACT_APPEND) &&
                   (used_in == MY_INDEX);

    assign match = tok_in.valid && (tok_in.action == ACT_LOOKUP) &&
                   (MY_INDEX < used_in) && (tok_in.ip_address != 32'd0) &&
                   (tok_in.ip_address >= start_reg) && (tok_in.ip_address <= end_reg);

    always_comb begin
        tok_next = tok_in;
        if (match) begin
            if (block_reg) begin
                tok_next.hit_block = 1'b1;
            end else begin
                tok_next.hit_trust = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            start_reg <= tok_in.range_start;
            end_reg   <= tok_in.range_end;
            block_reg <= tok_in.entry_is_block;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg  <= '0;
            used_reg <= '0;
        end else if (advance) begin
            tok_reg  <= tok_next;
            used_reg <= used_in;
        end
    end

    assign tok_out  = tok_reg;
    assign used_out = used_reg;

endmodule

### src/ip_range_trust_block_filter_unit.sv
// ============================================================================
// ip_range_trust_block_filter_unit
// IPv4 range access filter built as a chain of one cell per table entry.
// ============================================================================
// Path: the first cell register loads at the accepting edge; the token then
//   walks the MAX_ENTRIES cell registers in order to the output register.
// Throughput: one transaction per cycle unless the result stalls; every
//   transaction walks all MAX_ENTRIES cells, so appends and lookups stay ordered.
// A stalled result stalls the whole chain and s_ready drops with it.
// Reset (aresetn low, synchronous) empties the table and flushes the chain;
//   entry storage is not cleared and is only read below the fill count.
// ============================================================================
module ip_range_trust_block_filter_unit
    import ip_rtbf_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  s_payload_t s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output m_payload_t m_payload
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    // chain advances whenever the output register is free or being drained
    logic advance;
    logic s_accept;

    logic [CNT_W-1:0] entries_used_reg;
    logic [CNT_W-1:0] entries_used_next;
    logic [CNT_W-1:0] trust_entries_reg;
    logic [CNT_W-1:0] trust_entries_next;
    logic             full;

    tok_t             tok   [MAX_ENTRIES+1];
    logic [CNT_W-1:0] used  [MAX_ENTRIES+1];

    logic       m_valid_reg;
    m_payload_t m_payload_reg;
    m_payload_t m_payload_next;

    assign advance  = !m_valid_reg || m_ready;
    assign s_ready  = advance;
    assign s_accept = s_valid && s_ready;
    assign full     = (entries_used_reg >= MAX_CNT);

    // ------------------------------------------------------------------
    // Head: snapshot the table counters into the token and update them.
    // ------------------------------------------------------------------
    always_comb begin
        tok[0]                = '0;
        tok[0].valid          = s_accept;
        tok[0].action         = s_payload.action;
        tok[0].range_start    = s_payload.range_start;
        tok[0].range_end      = s_payload.range_end;
        tok[0].entry_is_block = s_payload.entry_is_block;
        tok[0].ip_address     = s_payload.ip_address;
        tok[0].trust_any      = (trust_entries_reg != '0);
        tok[0].empty          = (entries_used_reg == '0);
        // drop an append into a full table and flag it
        if ((s_payload.action == ACT_APPEND) && full) begin
            tok[0].action     = ACT_NONE;
            tok[0].table_full = 1'b1;
        end
        used[0] = entries_used_reg;

        entries_used_next  = entries_used_reg;
        trust_entries_next = trust_entries_reg;
        if (s_accept) begin
            unique case (s_payload.action)
                ACT_CLEAR: begin
                    entries_used_next  = '0;
                    trust_entries_next = '0;
                end
                ACT_APPEND: begin
                    if (!full) begin
                        entries_used_next  = entries_used_reg + CNT_W'(1);
                        trust_entries_next = trust_entries_reg +
                                             CNT_W'(!s_payload.entry_is_block);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_used_reg  <= '0;
            trust_entries_reg <= '0;
        end else begin
            entries_used_reg  <= entries_used_next;
            trust_entries_reg <= trust_entries_next;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: one table entry per cell.
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        ip_rtbf_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .CELL_INDEX  (gi)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .tok_in   (tok[gi]),
            .used_in  (used[gi]),
            .tok_out  (tok[gi+1]),
            .used_out (used[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // Tail: resolve the verdict and hold it in the output register.
    // ------------------------------------------------------------------
    always_comb begin
        m_payload_next.table_full = tok[MAX_ENTRIES].table_full;
        m_payload_next.is_blocked = 1'b0;
        if (tok[MAX_ENTRIES].action == ACT_LOOKUP && !tok[MAX_ENTRIES].empty) begin
            if (tok[MAX_ENTRIES].hit_block) begin
                m_payload_next.is_blocked = 1'b1;
            end else if (tok[MAX_ENTRIES].hit_trust) begin
                m_payload_next.is_blocked = 1'b0;
            end else begin
                m_payload_next.is_blocked = tok[MAX_ENTRIES].trust_any;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= tok[MAX_ENTRIES].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entries_used_reg <= MAX_CNT)
        else $error("fill count beyond table depth");

    a_trust_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        trust_entries_reg <= entries_used_reg)
        else $error("trust count exceeds fill count");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_payload.action == ACT_CLEAR) |=>
            (entries_used_reg == '0) && (trust_entries_reg == '0))
        else $error("clear did not empty the table");

    a_full_no_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.table_full |-> !m_payload.is_blocked)
        else $error("dropped append carries a verdict");

    a_full_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_payload.action == ACT_APPEND) && full |=>
            entries_used_reg == MAX_CNT)
        else $error("append into full table changed fill count");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the IPv4 range block/trust filter. A short table
// of directed transactions covers the empty table, address zero, reversed
// ranges, a full table and the unused action. It is followed by random
// sessions of clear, appends and lookups aimed at the stored ranges. Every
// accepted transaction is run through a behavioral copy of the filter. Each
// result is compared field by field with the oldest pending verdict, while
// both channels idle and stall at random.
// ============================================================================
module tb_top;
    import ip_rtbf_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int RAND_ITEMS  = 850;
    localparam int IDLE_LIMIT  = 4000;               // cycles with no handshake at all
    localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 8;
    localparam int PRINT_CAP   = 40;

    // Receiver stall styles, switched at random
    typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_MASK} rx_mode_e;

    // One row of the directed table; typed rows carry their verdict inline
    typedef struct {
        s_payload_t item;
        int         reps;
        bit         typed;
        m_payload_t want;
    } stim_row_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    s_payload_t s_payload = '0;
    logic       m_ready   = 1'b0;
    logic       s_ready;
    logic       m_valid;
    m_payload_t m_payload;

    // Verdict typed in by the directed table, sampled with the transaction
    logic       want_typed = 1'b0;
    m_payload_t want_fixed = '0;

    // Behavioral copy of the filter table
    logic [31:0] acl_lo  [TABLE_DEPTH];
    logic [31:0] acl_hi  [TABLE_DEPTH];
    logic        acl_blk [TABLE_DEPTH];
    int          acl_used   = 0;
    int          acl_trusts = 0;

    stim_row_t   dir_rows[$];                        // directed table
    m_payload_t  verdict_q[$];                       // verdicts still owed by the block
    logic [31:0] gen_lo[$];                          // ranges the generator aims lookups at
    logic [31:0] gen_hi[$];
    int          error_count  = 0;
    int          result_count = 0;
    int          items_sent   = 0;
    int          burst_left   = 0;
    bit          run_done     = 1'b0;

    rx_mode_e    rx_mode      = RX_STREAM;
    logic [7:0]  rx_mask      = 8'hFF;
    int          rx_left      = 0;

    ip_range_trust_block_filter_unit #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: apply one transaction to the table copy, return its verdict
    // ------------------------------------------------------------------------
    function automatic m_payload_t filter_verdict(input s_payload_t it);
        m_payload_t r;
        logic       fallback;
        logic       hit_block;
        r = '0;
        case (it.action)
            ACT_CLEAR: begin
                acl_used   = 0;
                acl_trusts = 0;
            end
            ACT_APPEND: begin
                if (acl_used >= TABLE_DEPTH) begin
                    r.table_full = 1'b1;             // drop, table untouched
                end else begin
                    acl_lo[acl_used]  = it.range_start;
                    acl_hi[acl_used]  = it.range_end;
                    acl_blk[acl_used] = it.entry_is_block;
                    acl_used++;
                    if (!it.entry_is_block) acl_trusts++;
                end
            end
            ACT_LOOKUP: begin
                if (acl_used != 0) begin
                    // default verdict blocks once any trust entry exists
                    fallback  = (acl_trusts != 0);
                    hit_block = 1'b0;
                    if (it.ip_address != 32'h0) begin
                        for (int i = 0; i < acl_used; i++) begin
                            if (it.ip_address >= acl_lo[i] && it.ip_address <= acl_hi[i]) begin
                                if (acl_blk[i]) hit_block = 1'b1;
                                else fallback = 1'b0;
                            end
                        end
                    end
                    r.is_blocked = hit_block | fallback;
                end
            end
            default: ;                               // unused action: no effect
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int idx, input logic got,
                                   input logic want);
        if (error_count < PRINT_CAP)
            $display("tb_top: result %0d %s: got %0b want %0b", idx, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: check results first, then record the accepted transaction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_payload_t want;
        m_payload_t pred;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("with no verdict pending", result_count, m_valid, 1'b0);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_payload.is_blocked !== want.is_blocked)
                        report_mismatch("is_blocked", result_count, m_payload.is_blocked,
                                        want.is_blocked);
                    if (m_payload.table_full !== want.table_full)
                        report_mismatch("table_full", result_count, m_payload.table_full,
                                        want.table_full);
                end
                result_count++;
            end
            if (s_valid && s_ready) begin
                // advance the table copy even when the row types its verdict
                pred = filter_verdict(s_payload);
                verdict_q.insert(verdict_q.size(), want_typed ? want_fixed : pred);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on a pattern that changes style every so often
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_mask = 8'($urandom) | 8'h01;
            rx_left = $urandom_range(40, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_STREAM: m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= rx_mask[rx_left % 8];
        endcase
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    // End a burst now and then: drop valid for a random gap, then start a new one
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Hold the transaction until the block takes it
    task automatic send_item(input s_payload_t it, input bit typed, input m_payload_t want);
        s_payload  <= it;
        s_valid    <= 1'b1;
        want_typed <= typed;
        want_fixed <= want;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pace_sender();
    endtask

    task automatic push_item(input s_payload_t it);
        send_item(it, 1'b0, '0);
        if (it.action != ACT_NONE) items_sent++;
    endtask

    // Drop valid and hold off until every owed verdict has come back
    task automatic wait_for_results();
        if (s_valid) s_valid <= 1'b0;
        do @(posedge aclk); while (verdict_q.size() != 0);
    endtask

    function automatic s_payload_t rand_payload();
        s_payload_t it;
        it.action         = 2'($urandom_range(0, 3));
        it.range_start    = $urandom;
        it.range_end      = $urandom;
        it.entry_is_block = 1'($urandom_range(0, 1));
        it.ip_address     = $urandom;
        return it;
    endfunction

    // Mostly narrow ranges so that lookups land both inside and around them
    function automatic void pick_range(output logic [31:0] lo, output logic [31:0] hi);
        logic [32:0] sum;
        lo = $urandom;
        case ($urandom_range(0, 9))
            0, 1: hi = lo;                           // single address
            2, 3, 4, 5: begin
                sum = {1'b0, lo} + {1'b0, $urandom_range(0, 4095)};
                hi  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            6: begin                                 // whole /8
                lo = {lo[31:24], 24'h00_0000};
                hi = {lo[31:24], 24'hFF_FFFF};
            end
            7: begin                                 // reversed, matches nothing
                if (lo == 32'h0) lo = 32'h8000_0000;
                hi = $urandom_range(lo - 1, 0);
            end
            8: hi = $urandom;
            default: begin                           // hug the ends of the space
                if ($urandom_range(0, 1)) begin
                    lo = 32'h0;
                    hi = $urandom_range(255, 0);
                end else begin
                    lo = 32'hFFFF_FF00 | $urandom_range(255, 0);
                    hi = 32'hFFFF_FFFF;
                end
            end
        endcase
    endfunction

    // Aim at a stored range, its edges or just past them; sometimes anywhere
    function automatic logic [31:0] pick_address();
        int          pick;
        int          idx;
        logic [31:0] lo;
        logic [31:0] hi;
        pick = $urandom_range(0, 19);
        if (gen_lo.size() == 0 || pick < 4) return $urandom;
        if (pick == 4) return 32'h0;
        if (pick == 5) return 32'hFFFF_FFFF;
        idx = $urandom_range(0, gen_lo.size() - 1);
        lo  = gen_lo[idx];
        hi  = gen_hi[idx];
        if (pick < 14) return (lo <= hi) ? $urandom_range(hi, lo) : lo;
        if (pick < 16) return lo;
        if (pick < 18) return hi;
        if (pick == 18) return lo - 1;
        return hi + 1;
    endfunction

    // Lookup, with some noise: an ignored action or a stray clear mid-session
    task automatic send_lookup();
        s_payload_t it;
        it = rand_payload();
        if ($urandom_range(0, 15) == 0) begin
            it.action = ACT_NONE;
        end else if ($urandom_range(0, 39) == 0) begin
            it.action = ACT_CLEAR;
            gen_lo.delete();
            gen_hi.delete();
        end else begin
            it.action     = ACT_LOOKUP;
            it.ip_address = pick_address();
        end
        push_item(it);
    endtask

    // Append one row to the directed table
    function automatic void add_row(input logic [1:0] act, input logic [31:0] lo,
                                    input logic [31:0] hi, input logic blk,
                                    input logic [31:0] addr, input int reps,
                                    input int typed, input int want_blk,
                                    input int want_full);
        stim_row_t row;
        row.item.action          = act;
        row.item.range_start     = lo;
        row.item.range_end       = hi;
        row.item.entry_is_block  = blk;
        row.item.ip_address      = addr;
        row.reps                 = reps;
        row.typed                = (typed != 0);
        row.want.is_blocked      = (want_blk != 0);
        row.want.table_full      = (want_full != 0);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        s_payload_t it;
        int         n_app;

        //      action      start          end            blk   address        n typed blk full
        // empty table never blocks, address zero included
        add_row(ACT_LOOKUP, 32'h0,         32'h0,         1'b0, 32'hFFFF_FFFF, 1, 1, 0, 0);
        add_row(ACT_LOOKUP, 32'h0,         32'h0,         1'b0, 32'h0,         1, 1, 0, 0);
        // unused action with every field high
        add_row(ACT_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1, 1, 0, 0);
        // block range, then inside it and outside it
        add_row(ACT_APPEND, 32'h0A00_0000, 32'h0AFF_FFFF, 1'b1, 32'h0,         1, 1, 0, 0);
        add_row(ACT_LOOKUP, 32'h0,         32'h0,         1'b0, 32'h0A12_3456, 1, 0, 0, 0);
        add_row(ACT_LOOKUP, 32'h0,         32'h0,         1'b0, 32'h0B00_0000, 1, 0, 0, 0);
        // single trusted address flips the default verdict
        add_row(ACT_APPEND, 32'hC0A8_0101, 32'hC0A8_0101, 1'b0, 32'h0,         1, 1, 0, 0);
        add_row(ACT_LOOKUP, 32'h0,         32'h0,         1'b0, 32'hC0A8_0101, 1, 0, 0, 0);
        add_row(ACT_LOOKUP, 32'h0,         32'h0,         1'b0, 32'hC0A8_0102, 1, 0, 0, 0);
        add_row(ACT_LOOKUP, 32'h0,         32'h0,         1'b0, 32'h0,         1, 0, 0, 0);
        // reversed trust range: counts, matches nothing
        add_row(ACT_APPEND, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0,         1, 1, 0, 0);
        add_row(ACT_LOOKUP, 32'h0,         32'h0,         1'b0, 32'h0000_0001, 1, 0, 0, 0);
        // block over the whole space beats any trust match
        add_row(ACT_APPEND, 32'h0,         32'hFFFF_FFFF, 1'b1, 32'h0,         1, 1, 0, 0);
        add_row(ACT_LOOKUP, 32'h0,         32'h0,         1'b0, 32'hC0A8_0101, 1, 0, 0, 0);
        // fill the table, then one append too many
        add_row(ACT_APPEND, 32'h1000_0000, 32'h1000_FFFF, 1'b0, 32'h0,
                TABLE_DEPTH - 4, 1, 0, 0);
        add_row(ACT_APPEND, 32'h0,         32'hFFFF_FFFF, 1'b1, 32'h0,         1, 1, 0, 1);
        add_row(ACT_LOOKUP, 32'h0,         32'h0,         1'b0, 32'h1000_0010, 1, 0, 0, 0);
        // clear empties the table again
        add_row(ACT_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1, 1, 0, 0);
        add_row(ACT_LOOKUP, 32'h0,         32'h0,         1'b0, 32'h1000_0010, 1, 1, 0, 0);
        // trusting address zero still leaves zero on the default verdict
        add_row(ACT_APPEND, 32'h0,         32'h0,         1'b0, 32'h0,         1, 1, 0, 0);
        add_row(ACT_LOOKUP, 32'h0,         32'h0,         1'b0, 32'h0,         1, 0, 0, 0);

        // hold reset, then release it once
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // walk the directed table
        foreach (dir_rows[i])
            repeat (dir_rows[i].reps)
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        // drain the chain completely once before the random part
        wait_for_results();

        // random sessions: clear, a run of appends with lookups mixed in, more lookups
        while (items_sent < RAND_ITEMS) begin
            it = rand_payload();
            it.action = ACT_CLEAR;
            push_item(it);
            gen_lo.delete();
            gen_hi.delete();

            // now and then push past a full table
            n_app = ($urandom_range(0, 7) == 0) ? $urandom_range(TABLE_DEPTH - 2, TABLE_DEPTH + 4)
                                                : $urandom_range(0, 6);
            for (int k = 0; k < n_app; k++) begin
                it = rand_payload();
                it.action = ACT_APPEND;
                pick_range(it.range_start, it.range_end);
                if (gen_lo.size() < TABLE_DEPTH) begin
                    gen_lo.insert(gen_lo.size(), it.range_start);
                    gen_hi.insert(gen_hi.size(), it.range_end);
                end
                push_item(it);
                repeat ($urandom_range(0, 2)) send_lookup();
            end
            repeat ($urandom_range(3, 12)) send_lookup();

            if ($urandom_range(0, 5) == 0) wait_for_results();
        end

        // let every verdict come back, then watch for stray results
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        run_done = 1'b1;
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when neither channel moves for too long
    // ------------------------------------------------------------------------
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (!run_done && idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        if (!run_done) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

endmodule
